[hw/rtl/pgf_pkg.sv]
// ---------------------------------------------------------------------------
// pgf_pkg
// Shared types and constants of the packet gap filler: field widths,
// register indexes, blocks-per-second values and the request structures
// passed between the front, the queue and the back.
// ---------------------------------------------------------------------------
package pgf_pkg;

	// Field widths.
	localparam int SEC_W   = 32;
	localparam int BLK_W   = 18;
	localparam int DIFF_W  = BLK_W + 1;
	localparam int BPP_W   = 8;
	localparam int CHUNK_W = 7;
	localparam int CNT_W   = 32;
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 8;

	// Largest chunk the design is built for.
	localparam int MAX_CHUNK_DEF = 64;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_BPP  = 2'd0;
	localparam logic [IDX_W-1:0] REG_PPC  = 2'd1;
	localparam logic [IDX_W-1:0] REG_MODE = 2'd2;

	// Register reset values.
	localparam logic [BPP_W-1:0]   BPP_RST  = 8'd16;
	localparam logic [CHUNK_W-1:0] PPC_RST  = 7'd64;
	localparam logic               MODE_RST = 1'b0;

	// Blocks per second: alternating at 200 MHz, fixed at 160 MHz.
	localparam logic [BLK_W-1:0] TOT_EVEN  = 18'd195313;
	localparam logic [BLK_W-1:0] TOT_ODD   = 18'd195312;
	localparam logic [BLK_W-1:0] TOT_FIXED = 18'd156250;

	// Largest forward jump of the stamp, in seconds.
	localparam logic [SEC_W:0] AHEAD_LIMIT = 33'd10;

	// Stamp value that marks an invalid header.
	localparam logic [SEC_W-1:0] STAMP_BAD = '1;

	typedef struct packed {
		logic [BPP_W-1:0]   bpp;
		logic [CHUNK_W-1:0] ppc;
		logic               mode;
	} cfg_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic [SEC_W-1:0]   start_sec;
		logic [BLK_W-1:0]   start_blk;
		logic [BLK_W-1:0]   tot;
		logic [BPP_W-1:0]   bpp;
		logic [CHUNK_W-1:0] fills;
		logic               dropped;
		logic               hdr_end;
		logic [SEC_W-1:0]   stamp;
		logic [BLK_W-1:0]   blk;
		logic [CNT_W-1:0]   acc;
		logic [CNT_W-1:0]   rej;
	} job_t;

	// Position reported back after the fills of a dropped request.
	typedef struct packed {
		logic             valid;
		logic [SEC_W-1:0] sec;
		logic [BLK_W-1:0] blk;
	} pos_t;

endpackage

[hw/rtl/pgf_div.sv]
// ---------------------------------------------------------------------------
// pgf_div
// Restoring divider of the block distance by the blocks per packet, one
// quotient bit per cycle.
// ---------------------------------------------------------------------------
module pgf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pgf_pkg::DIFF_W-1:0]  dividend,
	input  logic [pgf_pkg::BPP_W-1:0]   divisor,
	output logic                        done,
	output logic [pgf_pkg::DIFF_W-1:0]  quotient
);

	localparam int DW  = pgf_pkg::DIFF_W;
	localparam int VW  = pgf_pkg::BPP_W;
	localparam int CW  = $clog2(DW);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;

	logic [VW:0]   trial;
	logic [VW:0]   sub;
	logic          ge;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		sub   = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and a shift register that trades dividend bits
	// for quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? sub[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/pgf_queue.sv]
// ---------------------------------------------------------------------------
// pgf_queue
// Two-entry queue of classified requests between the front and the back.
// ---------------------------------------------------------------------------
module pgf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pgf_pkg::job_t    push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output pgf_pkg::job_t    head
);

	pgf_pkg::job_t mem [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem[rd_ptr_q];

endmodule

[hw/rtl/pgf_front.sv]
// ---------------------------------------------------------------------------
// pgf_front
// Takes one header, checks it against the last position, works out the
// number of fill packets and queues a request for the back.
// ---------------------------------------------------------------------------
module pgf_front #(
	parameter int MAX_CHUNK = pgf_pkg::MAX_CHUNK_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pgf_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pgf_pkg::SEC_W-1:0]  stamp_seconds,
	input  logic [pgf_pkg::BLK_W-1:0]  block_number,
	input  logic                       q_full,
	output logic                       q_push,
	output pgf_pkg::job_t              q_data,
	input  pgf_pkg::pos_t              pos
);

	localparam int SLOT_W = $clog2(MAX_CHUNK + 1);
	localparam int SEC_W  = pgf_pkg::SEC_W;
	localparam int BLK_W  = pgf_pkg::BLK_W;
	localparam int DIFF_W = pgf_pkg::DIFF_W;
	localparam int BPP_W  = pgf_pkg::BPP_W;
	localparam int CNT_W  = pgf_pkg::CNT_W;

	typedef enum logic [2:0] {
		F_IDLE,
		F_CHECK,
		F_DIV,
		F_PUSH,
		F_WAIT
	} fstate_t;

	fstate_t             state_q;
	logic [SEC_W-1:0]    stamp_q;
	logic [BLK_W-1:0]    blk_q;
	logic [SEC_W-1:0]    last_sec_q;
	logic [BLK_W-1:0]    last_blk_q;
	logic                have_ref_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    acc_q;
	logic [CNT_W-1:0]    rej_q;
	logic [DIFF_W-1:0]   diff_q;
	logic [BLK_W-1:0]    tot_q;
	logic [BPP_W-1:0]    bpp_q;
	logic [SLOT_W-1:0]   room_q;
	logic [SLOT_W-1:0]   fills_q;
	logic                dropped_q;
	logic                hdr_end_q;
	logic                div_start_q;

	logic                div_done;
	logic [DIFF_W-1:0]   quotient;

	logic [SLOT_W-1:0]   chunk_n;
	logic [SLOT_W-1:0]   slot_eff;
	logic [BPP_W-1:0]    bpp_eff;
	logic                ahead;
	logic [BLK_W-1:0]    tot_w;
	logic [DIFF_W-1:0]   diff_w;
	logic                short_w;
	logic [DIFF_W-1:0]   q_m1;
	logic [SLOT_W-1:0]   fills_w;
	logic [SLOT_W-1:0]   slot_next;

	// Header checks against the last position.
	always_comb begin
		if (cfg.ppc == '0) begin
			chunk_n = SLOT_W'(1);
		end else if (cfg.ppc > pgf_pkg::CHUNK_W'(MAX_CHUNK)) begin
			chunk_n = SLOT_W'(MAX_CHUNK);
		end else begin
			chunk_n = cfg.ppc[SLOT_W-1:0];
		end
		slot_eff = (slot_q >= chunk_n) ? '0 : slot_q;
		bpp_eff  = (cfg.bpp == '0) ? BPP_W'(1) : cfg.bpp;
		ahead    = ({1'b0, last_sec_q} + pgf_pkg::AHEAD_LIMIT) < {1'b0, stamp_q};
		if (cfg.mode) begin
			tot_w = pgf_pkg::TOT_FIXED;
		end else begin
			tot_w = last_sec_q[0] ? pgf_pkg::TOT_ODD : pgf_pkg::TOT_EVEN;
		end
		if (blk_q >= last_blk_q) begin
			diff_w = {1'b0, blk_q} - {1'b0, last_blk_q};
		end else begin
			diff_w = {1'b0, blk_q} + {1'b0, tot_w} - {1'b0, last_blk_q};
		end
		short_w = diff_w < DIFF_W'(bpp_eff);
	end

	// Fill count, limited by the slots left in the chunk.
	always_comb begin
		q_m1      = quotient - 1'b1;
		fills_w   = (q_m1 < DIFF_W'(room_q)) ? q_m1[SLOT_W-1:0] : room_q;
		slot_next = slot_q + fills_q + 1'b1;
	end

	// Sequencer and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			last_sec_q  <= '0;
			last_blk_q  <= '0;
			have_ref_q  <= 1'b0;
			slot_q      <= '0;
			acc_q       <= '0;
			rej_q       <= '0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					slot_q <= slot_eff;
					priority if (stamp_q == pgf_pkg::STAMP_BAD) begin
						rej_q   <= rej_q + 1'b1;
						state_q <= F_IDLE;
					end else if (!have_ref_q) begin
						// The first header only sets the reference; it counts as rejected.
						have_ref_q <= 1'b1;
						last_sec_q <= stamp_q;
						last_blk_q <= blk_q;
						rej_q      <= rej_q + 1'b1;
						state_q    <= F_IDLE;
					end else if (ahead || short_w) begin
						rej_q   <= rej_q + 1'b1;
						state_q <= F_IDLE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= F_DIV;
					end
				end
				F_DIV: begin
					if (div_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						if (dropped_q) begin
							slot_q  <= '0;
							state_q <= F_WAIT;
						end else begin
							acc_q      <= acc_q + 1'b1;
							last_sec_q <= stamp_q;
							last_blk_q <= blk_q;
							slot_q     <= hdr_end_q ? '0 : slot_next;
							state_q    <= F_IDLE;
						end
					end
				end
				F_WAIT: begin
					if (pos.valid) begin
						last_sec_q <= pos.sec;
						last_blk_q <= pos.blk;
						state_q    <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Request payload registers.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			stamp_q <= stamp_seconds;
			blk_q   <= block_number;
		end
		if (state_q == F_CHECK) begin
			diff_q <= diff_w;
			tot_q  <= tot_w;
			bpp_q  <= bpp_eff;
			room_q <= chunk_n - slot_eff;
		end
		if (state_q == F_DIV && div_done) begin
			fills_q   <= fills_w;
			dropped_q <= fills_w == room_q;
			hdr_end_q <= (fills_w + 1'b1) == room_q;
		end
	end

	pgf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (diff_q),
		.divisor  (bpp_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Request to the back.
	always_comb begin
		q_data.start_sec = last_sec_q;
		q_data.start_blk = last_blk_q;
		q_data.tot       = tot_q;
		q_data.bpp       = bpp_q;
		q_data.fills     = pgf_pkg::CHUNK_W'(fills_q);
		q_data.dropped   = dropped_q;
		q_data.hdr_end   = hdr_end_q;
		q_data.stamp     = stamp_q;
		q_data.blk       = blk_q;
		q_data.acc       = dropped_q ? acc_q : acc_q + 1'b1;
		q_data.rej       = rej_q;
	end

	assign q_push   = (state_q == F_PUSH) && !q_full;
	assign in_ready = state_q == F_IDLE;

endmodule

[hw/rtl/pgf_back.sv]
// ---------------------------------------------------------------------------
// pgf_back
// Carries out one queued request: its fill headers, then the received header
// if the fills leave room; one per unstalled cycle into the output register.
// ---------------------------------------------------------------------------
module pgf_back #(
	parameter int MAX_CHUNK = pgf_pkg::MAX_CHUNK_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  pgf_pkg::job_t              q_head,
	output logic                       q_pop,
	output pgf_pkg::pos_t              pos,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pgf_pkg::SEC_W-1:0]  out_seconds,
	output logic [pgf_pkg::BLK_W-1:0]  out_block,
	output logic                       is_fill,
	output logic                       chunk_end,
	output logic                       last,
	output logic [pgf_pkg::CNT_W-1:0]  accepted_total,
	output logic [pgf_pkg::CNT_W-1:0]  rejected_total
);

	localparam int SLOT_W = $clog2(MAX_CHUNK + 1);
	localparam int SEC_W  = pgf_pkg::SEC_W;
	localparam int BLK_W  = pgf_pkg::BLK_W;
	localparam int DIFF_W = pgf_pkg::DIFF_W;
	localparam int CNT_W  = pgf_pkg::CNT_W;

	logic                busy_q;
	pgf_pkg::job_t       job_q;
	logic [SEC_W-1:0]    cur_sec_q;
	logic [BLK_W-1:0]    cur_blk_q;
	logic [SLOT_W-1:0]   left_q;
	logic                pos_valid_q;
	logic [SEC_W-1:0]    pos_sec_q;
	logic [BLK_W-1:0]    pos_blk_q;

	logic                out_valid_q;
	logic [SEC_W-1:0]    out_sec_q;
	logic [BLK_W-1:0]    out_blk_q;
	logic                is_fill_q;
	logic                chunk_end_q;
	logic                last_q;
	logic [CNT_W-1:0]    acc_q;
	logic [CNT_W-1:0]    rej_q;

	logic                step;
	logic                do_fill;
	logic                final_fill;
	logic [DIFF_W-1:0]   nb;
	logic                wrap;
	logic [BLK_W-1:0]    nblk;
	logic [SEC_W-1:0]    nsec;

	// Next fill position: one packet on, wrapping into the next second.
	always_comb begin
		step       = busy_q && (!out_valid_q || out_ready);
		do_fill    = left_q != '0;
		final_fill = job_q.dropped && (left_q == SLOT_W'(1));
		nb         = {1'b0, cur_blk_q} + DIFF_W'(job_q.bpp);
		wrap       = nb >= {1'b0, job_q.tot};
		nblk       = wrap ? BLK_W'(nb - {1'b0, job_q.tot}) : nb[BLK_W-1:0];
		nsec       = cur_sec_q + SEC_W'(wrap);
	end

	assign q_pop = !busy_q && q_not_empty;

	// Control: request in hand, output valid and the position report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pos_valid_q <= 1'b0;
		end else begin
			pos_valid_q <= 1'b0;
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (step && (!do_fill || final_fill)) begin
				busy_q      <= 1'b0;
				pos_valid_q <= final_fill && do_fill;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath of the request and of the output register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q     <= q_head;
			cur_sec_q <= q_head.start_sec;
			cur_blk_q <= q_head.start_blk;
			left_q    <= SLOT_W'(q_head.fills);
		end else if (step && do_fill) begin
			cur_sec_q <= nsec;
			cur_blk_q <= nblk;
			left_q    <= left_q - 1'b1;
		end
		if (step) begin
			acc_q <= job_q.acc;
			rej_q <= job_q.rej;
			if (do_fill) begin
				out_sec_q   <= nsec;
				out_blk_q   <= nblk;
				is_fill_q   <= 1'b1;
				chunk_end_q <= final_fill;
				last_q      <= final_fill;
				pos_sec_q   <= nsec;
				pos_blk_q   <= nblk;
			end else begin
				out_sec_q   <= job_q.stamp;
				out_blk_q   <= job_q.blk;
				is_fill_q   <= 1'b0;
				chunk_end_q <= job_q.hdr_end;
				last_q      <= 1'b1;
			end
		end
	end

	assign pos.valid      = pos_valid_q;
	assign pos.sec        = pos_sec_q;
	assign pos.blk        = pos_blk_q;
	assign out_valid      = out_valid_q;
	assign out_seconds    = out_sec_q;
	assign out_block      = out_blk_q;
	assign is_fill        = is_fill_q;
	assign chunk_end      = chunk_end_q;
	assign last           = last_q;
	assign accepted_total = acc_q;
	assign rejected_total = rej_q;

endmodule

[hw/rtl/packet_gap_filler_unit.sv]
// ---------------------------------------------------------------------------
// packet_gap_filler_unit
// Sequence gap detector and filler for received packet headers.
// ---------------------------------------------------------------------------
// Usage: headers (stamp_seconds, block_number) enter on the in_valid/in_ready
// channel. Each request is checked against the last position and gives no
// result (rejected), or a run of fill headers followed by the received
// header, or only fill headers when they close the chunk. Results leave on
// the out_valid/out_ready channel, one per cycle while the receiver takes
// them; last marks the final result of a request.
// Each accepted header is checked against the last position; a bit-serial
// divider divides its block distance by the blocks per packet. The front takes
// no new header until the last one is queued or rejected. Fills follow at one
// a cycle through the two-entry request queue; a header that closes its chunk
// with fills holds the front until the back reports the final fill position.
// Reset clears the position, the chunk slot count, both counters and the
// registers to their defaults. A stalled receiver holds the output register;
// the back stops and, once the queue fills, the front stops taking headers.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, and the block itself does not enforce it.
// ---------------------------------------------------------------------------
module packet_gap_filler_unit #(
	parameter int MAX_CHUNK = pgf_pkg::MAX_CHUNK_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [pgf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [pgf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pgf_pkg::SEC_W-1:0]  stamp_seconds,
	input  logic [pgf_pkg::BLK_W-1:0]  block_number,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pgf_pkg::SEC_W-1:0]  out_seconds,
	output logic [pgf_pkg::BLK_W-1:0]  out_block,
	output logic                       is_fill,
	output logic                       chunk_end,
	output logic                       last,
	output logic [pgf_pkg::CNT_W-1:0]  accepted_total,
	output logic [pgf_pkg::CNT_W-1:0]  rejected_total
);

	pgf_pkg::cfg_t  cfg_q;
	pgf_pkg::job_t  q_data;
	pgf_pkg::job_t  q_head;
	pgf_pkg::pos_t  pos;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_not_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp  <= pgf_pkg::BPP_RST;
			cfg_q.ppc  <= pgf_pkg::PPC_RST;
			cfg_q.mode <= pgf_pkg::MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgf_pkg::REG_BPP:  cfg_q.bpp  <= cfg_data;
				pgf_pkg::REG_PPC:  cfg_q.ppc  <= cfg_data[pgf_pkg::CHUNK_W-1:0];
				pgf_pkg::REG_MODE: cfg_q.mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pgf_front #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stamp_seconds (stamp_seconds),
		.block_number  (block_number),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_data),
		.pos           (pos)
	);

	pgf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	pgf_back #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.pos            (pos),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_seconds    (out_seconds),
		.out_block      (out_block),
		.is_fill        (is_fill),
		.chunk_end      (chunk_end),
		.last           (last),
		.accepted_total (accepted_total),
		.rejected_total (rejected_total)
	);

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for packet_gap_filler_unit
// Drives packet headers through the valid/ready input and predicts every
// emitted header (fills and received ones) from a behavioural copy of the
// position, chunk and counter state. Each emitted header is compared field by
// field with the oldest prediction. Directed cases come first, then random
// traffic under several register settings, with idle gaps on both sides, a
// long output stall and a sender pause.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pgf_pkg::*;

	localparam int CHUNK_CAP = MAX_CHUNK_DEF;
	// Time for the block to finish a header; a rejected one gives no result.
	localparam int SETTLE_CYCLES = 64;
	localparam int LONG_HOLD_CYCLES = 400;
	// Slowest correct run: ~400 headers, each up to 64 results that may each
	// wait out a receiver stall, plus sender gaps; the limit allows 4x that.
	localparam int unsigned CYCLE_LIMIT = 5_000_000;

	// One emitted header as the block should present it.
	typedef struct {
		logic [SEC_W-1:0] sec;
		logic [BLK_W-1:0] blk;
		logic             fill;
		logic             chunk_end;
		logic             last;
		logic [CNT_W-1:0] acc;
		logic [CNT_W-1:0] rej;
	} header_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [SEC_W-1:0]   stamp_seconds;
	logic [BLK_W-1:0]   block_number;
	logic               out_valid;
	logic               out_ready;
	logic [SEC_W-1:0]   out_seconds;
	logic [BLK_W-1:0]   out_block;
	logic               is_fill;
	logic               chunk_end;
	logic               last;
	logic [CNT_W-1:0]   accepted_total;
	logic [CNT_W-1:0]   rejected_total;

	// Predicted headers still to be emitted, oldest first.
	header_result_t due_headers[$];

	// Register mirror and position state of the predictor.
	logic [BPP_W-1:0]   cfg_bpp;
	logic [CHUNK_W-1:0] cfg_ppc;
	logic               cfg_mode;
	logic [SEC_W-1:0]   pos_sec;
	logic [BLK_W-1:0]   pos_blk;
	logic               have_ref;
	int unsigned        slots_used;
	logic [CNT_W-1:0]   accepted_cnt;
	logic [CNT_W-1:0]   rejected_cnt;

	int          mismatches;
	int unsigned cycle_count;
	bit          steady_send;
	bit          steady_recv;
	bit          long_hold_req;

	packet_gap_filler_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.stamp_seconds  (stamp_seconds),
		.block_number   (block_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_seconds    (out_seconds),
		.out_block      (out_block),
		.is_fill        (is_fill),
		.chunk_end      (chunk_end),
		.last           (last),
		.accepted_total (accepted_total),
		.rejected_total (rejected_total)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Works out the headers emitted for one accepted request and queues them.
	task automatic predict_header(input logic [SEC_W-1:0] stamp, input logic [BLK_W-1:0] blk);
		header_result_t run[$];
		header_result_t res;
		int unsigned pkt, chunk, tot, distance, missing, fills, nb;
		pkt = (cfg_bpp == '0) ? 1 : cfg_bpp;
		chunk = (cfg_ppc == '0) ? 1 : ((cfg_ppc > CHUNK_CAP) ? CHUNK_CAP : cfg_ppc);
		// A chunk shrunk below its used slots starts afresh.
		if (slots_used >= chunk)
			slots_used = 0;
		if (stamp == STAMP_BAD) begin
			rejected_cnt++;
			return;
		end
		if (!have_ref) begin
			have_ref = 1'b1;
			pos_sec = stamp;
			pos_blk = blk;
		end
		if ({1'b0, pos_sec} + AHEAD_LIMIT < {1'b0, stamp}) begin
			rejected_cnt++;
			return;
		end
		tot = cfg_mode ? TOT_FIXED : (pos_sec[0] ? TOT_ODD : TOT_EVEN);
		distance = (blk >= pos_blk) ? blk - pos_blk : blk + tot - pos_blk;
		if (distance < pkt) begin
			rejected_cnt++;
			return;
		end
		missing = distance / pkt - 1;
		fills = (missing < chunk - slots_used) ? missing : chunk - slots_used;
		// Fill headers step the position one packet at a time.
		repeat (fills) begin
			nb = pos_blk + pkt;
			if (nb >= tot)
				pos_sec++;
			pos_blk = BLK_W'(nb % tot);
			slots_used++;
			res.sec = pos_sec;
			res.blk = pos_blk;
			res.fill = 1'b1;
			res.chunk_end = (slots_used == chunk);
			run.push_back(res);
		end
		// A header whose chunk was closed by its fills is dropped.
		if (slots_used == chunk) begin
			slots_used = 0;
		end else begin
			accepted_cnt++;
			pos_sec = stamp;
			pos_blk = blk;
			slots_used++;
			res.sec = stamp;
			res.blk = blk;
			res.fill = 1'b0;
			res.chunk_end = (slots_used == chunk);
			run.push_back(res);
			if (slots_used == chunk)
				slots_used = 0;
		end
		foreach (run[i]) begin
			run[i].last = (i == run.size() - 1);
			run[i].acc = accepted_cnt;
			run[i].rej = rejected_cnt;
			due_headers.push_back(run[i]);
		end
	endtask

	// Offers one request, predicts it once taken, then idles for a while.
	task automatic send_header(input logic [SEC_W-1:0] stamp, input logic [BLK_W-1:0] blk);
		int gap;
		in_valid <= 1'b1;
		stamp_seconds <= stamp;
		block_number <= blk;
		do
			@(posedge clk);
		while (!in_ready);
		predict_header(stamp, blk);
		gap = steady_send ? 0 : pick_idle();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every predicted header has come out.
	task automatic wait_results();
		while (due_headers.size() != 0)
			@(posedge clk);
	endtask

	// Stops sending and lets the block finish any request without results.
	task automatic settle_block();
		in_valid <= 1'b0;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers while the block is idle.
	task automatic apply_settings(input logic [CFG_W-1:0] bpp, input logic [CFG_W-1:0] ppc,
			input logic [CFG_W-1:0] mode);
		settle_block();
		cfg_we <= 1'b1;
		cfg_index <= REG_BPP;
		cfg_data <= bpp;
		@(posedge clk);
		cfg_index <= REG_PPC;
		cfg_data <= ppc;
		@(posedge clk);
		cfg_index <= REG_MODE;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_bpp = bpp[BPP_W-1:0];
		cfg_ppc = ppc[CHUNK_W-1:0];
		cfg_mode = mode[0];
	endtask

	// Chooses a header: mostly the next packets in sequence, the rest
	// duplicates, stamps ahead or behind, invalid stamps and noise.
	task automatic pick_header(output logic [SEC_W-1:0] stamp, output logic [BLK_W-1:0] blk);
		int unsigned pkt, tot, steps, nb, kind;
		logic [SEC_W-1:0] sec;
		pkt = (cfg_bpp == '0) ? 1 : cfg_bpp;
		tot = cfg_mode ? TOT_FIXED : (pos_sec[0] ? TOT_ODD : TOT_EVEN);
		kind = $urandom_range(0, 99);
		sec = pos_sec;
		if (kind < 72) begin
			steps = (kind < 40) ? 1 : ((kind < 62) ? $urandom_range(2, 4) : $urandom_range(5, 90));
			nb = pos_blk + steps * pkt;
			if (kind % 6 == 0)
				nb += $urandom_range(0, pkt - 1);
			while (nb >= tot) begin
				nb -= tot;
				sec++;
			end
			stamp = sec;
			blk = BLK_W'(nb);
		end else if (kind < 80) begin
			stamp = sec;
			blk = BLK_W'(pos_blk + $urandom_range(0, pkt - 1));
		end else if (kind < 86) begin
			stamp = sec + $urandom_range(11, 5000);
			blk = BLK_W'(pos_blk + pkt);
		end else if (kind < 90) begin
			stamp = sec - $urandom_range(1, 5000);
			blk = BLK_W'(pos_blk + pkt);
		end else if (kind < 93) begin
			stamp = STAMP_BAD;
			blk = BLK_W'($urandom_range(0, 2 ** BLK_W - 1));
		end else begin
			stamp = $urandom;
			blk = BLK_W'($urandom_range(0, 2 ** BLK_W - 1));
		end
	endtask

	task automatic random_headers(input int count);
		logic [SEC_W-1:0] stamp;
		logic [BLK_W-1:0] blk;
		repeat (count) begin
			pick_header(stamp, blk);
			send_header(stamp, blk);
		end
	endtask

	// Reset values, reference setting, rejection rules and a second crossing
	// near the top of the stamp range.
	task automatic test_directed_high();
		send_header(STAMP_BAD, 18'd5);
		send_header(32'hFFFF_FFF8, 18'd195200);
		send_header(32'hFFFF_FFF8, 18'd195200);
		send_header(32'hFFFF_FFF8, 18'd195216);
		send_header(32'hFFFF_FFF8, 18'd195220);
		send_header(32'hFFFF_FFF9, 18'd195);
		send_header(32'hFFFF_FFFE, 18'd211);
	endtask

	// Fills walk the position over two second boundaries, so that the
	// seconds stamp wraps from all ones to zero.
	task automatic test_stamp_wrap();
		int guard;
		apply_settings(8'd255, 8'd64, 8'd0);
		guard = 0;
		while (pos_sec != '0 && guard < 40) begin
			send_header(STAMP_BAD - 1, pos_blk - 1'b1);
			guard++;
		end
	endtask

	// Stamp limits near zero, small gaps, duplicates, wrapped and oversized
	// block numbers, and an invalid stamp after the reference.
	task automatic test_directed_low();
		apply_settings(8'd16, 8'd64, 8'd0);
		send_header(32'd10, pos_blk + 18'd16);
		send_header(32'd21, pos_blk + 18'd16);
		send_header(32'd0, pos_blk + 18'd48);
		send_header(32'd0, pos_blk + 18'd17);
		send_header(32'd0, pos_blk);
		send_header(32'd0, pos_blk + 18'd15);
		send_header(32'd0, pos_blk - 18'd5);
		send_header(32'd0, '1);
		send_header(STAMP_BAD, pos_blk + 18'd16);
	endtask

	// Random traffic over several settings, the extremes among them.
	task automatic test_random_traffic();
		apply_settings(8'd16, 8'd64, 8'd0);
		random_headers(80);
		apply_settings(8'd1, 8'd1, 8'd1);
		random_headers(50);
		apply_settings(8'd0, 8'd0, 8'd0);
		random_headers(40);
		apply_settings(8'd2, 8'd33, 8'd1);
		random_headers(20);
	endtask

	// A stretch with no idling on either side.
	task automatic test_steady_traffic();
		apply_settings(8'd255, 8'd7, 8'd1);
		steady_send = 1'b1;
		steady_recv = 1'b1;
		random_headers(40);
		steady_send = 1'b0;
		steady_recv = 1'b0;
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the block fills up and stops taking them.
	task automatic test_output_backpressure();
		apply_settings(8'd100, 8'hE4, 8'h81);
		long_hold_req = 1'b1;
		steady_send = 1'b1;
		random_headers(60);
		steady_send = 1'b0;
	endtask

	// The sender pauses until every predicted header has arrived.
	task automatic test_sender_pause();
		apply_settings(CFG_W'($urandom_range(1, 255)), CFG_W'($urandom_range(1, 64)),
			CFG_W'($urandom_range(0, 1)));
		random_headers(30);
		in_valid <= 1'b0;
		wait_results();
		random_headers(30);
	endtask

	// Receiver: random stalls, plus the long hold-off when asked for.
	initial begin : result_receiver
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end else if (hold == 0 && !steady_recv) begin
				hold = pick_idle();
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Checks each emitted header against the oldest prediction.
	always @(posedge clk) begin
		header_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (due_headers.size() == 0) begin
				$error("header emitted with none predicted: seconds %0h block %0h",
					out_seconds, out_block);
				mismatches++;
			end else begin
				want = due_headers.pop_front();
				compare_field("out_seconds", want.sec, out_seconds);
				compare_field("out_block", CNT_W'(want.blk), CNT_W'(out_block));
				compare_field("is_fill", CNT_W'(want.fill), CNT_W'(is_fill));
				compare_field("chunk_end", CNT_W'(want.chunk_end), CNT_W'(chunk_end));
				compare_field("last", CNT_W'(want.last), CNT_W'(last));
				compare_field("accepted_total", want.acc, accepted_total);
				compare_field("rejected_total", want.rej, rejected_total);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("packet_gap_filler_unit verification failed");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BPP;
		cfg_data <= '0;
		in_valid <= 1'b0;
		stamp_seconds <= '0;
		block_number <= '0;
		mismatches = 0;
		cycle_count = 0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		long_hold_req = 1'b0;
		cfg_bpp = BPP_RST;
		cfg_ppc = PPC_RST;
		cfg_mode = MODE_RST;
		pos_sec = '0;
		pos_blk = '0;
		have_ref = 1'b0;
		slots_used = 0;
		accepted_cnt = '0;
		rejected_cnt = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_high();
		test_stamp_wrap();
		test_directed_low();
		test_random_traffic();
		test_steady_traffic();
		test_output_backpressure();
		test_sender_pause();

		settle_block();
		if (mismatches == 0 && due_headers.size() == 0)
			$display("packet_gap_filler_unit verification clean");
		else
			$display("packet_gap_filler_unit verification failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/pgf_pkg.sv
hw/rtl/pgf_div.sv
hw/rtl/pgf_queue.sv
hw/rtl/pgf_front.sv
hw/rtl/pgf_back.sv
hw/rtl/packet_gap_filler_unit.sv
tb/sv/testbench.sv
